### rtl/core/scfl_pkg.sv
// Package for the step cache: sequencer states, result status codes,
// register indexes and fixed field widths. No dependencies.
package scfl_pkg;

    // Fixed field widths
    localparam int STEP_W   = 20;
    localparam int TOTAL_W  = 21;
    localparam int WAYS_W   = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 21;

    // Reset way count
    localparam logic [WAYS_W-1:0] DEFAULT_WAYS = 4'd5;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CACHE_READY = 2'd0,
        REG_TOTAL_STEPS = 2'd1,
        REG_WAYS_IN_USE = 2'd2
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_REFUSED   = 2'd0,
        STATUS_HIT       = 2'd1,
        STATUS_FILLED    = 2'd2,
        STATUS_FETCH_ERR = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

endpackage

### rtl/core/step_cache_fifo_lookup.sv
// Step cache top level: fully associative step-to-slot lookup with FIFO eviction.
// Depends on scfl_pkg for states, status codes, register indexes and widths.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid / tready  | tdata: step[19:0]; tuser: fetch_ok
//  m_axis    | out | m_axis_tvalid / tready  | tdata: slot[2:0]; tuser: status[1:0]
//  cfg       | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A missing word is accepted, then compared against each of the W ways (W =
// effective way count), one tag compare per cycle through the single tag
// memory read port, then handed to the output register. A hit at logical
// position k stops the scan early; a refused word skips the scan.
// Reset clears the valid bits, head pointer and sequencer at once; no sweep.
// The input is not ready while a word is in flight; a stalled output holds the
// sequencer in its last state until the result register frees.
module step_cache_fifo_lookup #(
    parameter int MAX_WAYS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // step[19:0], zero pad
    input  logic                              s_axis_tuser,  // fetch_ok
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // slot[2:0], zero pad
    output logic [scfl_pkg::STATUS_W-1:0]     m_axis_tuser,  // status[1:0]
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scfl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import scfl_pkg::*;

    localparam int PTR_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW    = $clog2(MAX_WAYS + 1);
    localparam int CW    = (EW > WAYS_W) ? EW : WAYS_W;

    // Configuration registers
    logic                  cache_ready_reg;
    logic [TOTAL_W-1:0]    total_steps_reg;
    logic [WAYS_W-1:0]     ways_reg;

    // Cache state
    logic [MAX_WAYS-1:0]   valid_reg, valid_next;
    logic [PTR_W-1:0]      oldest_reg, oldest_next;
    logic [STEP_W-1:0]     tag_mem [MAX_WAYS];
    logic [STEP_W-1:0]     rd_data_reg;

    // Request and scan registers
    seq_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  ok_reg, ok_next;
    logic [PTR_W-1:0]      cmp_ptr_reg, cmp_ptr_next;
    logic [PTR_W-1:0]      cnt_reg, cnt_next;
    logic                  empty_found_reg, empty_found_next;
    logic [PTR_W-1:0]      empty_ptr_reg, empty_ptr_next;
    status_t               res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;

    // Decode signals
    logic [CW-1:0]         ways_ext;
    logic [CW-1:0]         eff_ways;
    logic [PTR_W-1:0]      last_idx;
    logic [PTR_W-1:0]      cmp_ptr_inc;
    logic [PTR_W-1:0]      oldest_inc;
    logic                  in_accept;
    logic                  refused;
    logic                  hit_now;
    logic                  last_now;
    logic                  empty_now;
    logic [PTR_W-1:0]      chosen;
    logic                  out_free;
    logic                  cfg_we;
    logic [PTR_W-1:0]      rd_addr;
    logic                  tag_we;

    // Effective way count, clamped to one through MAX_WAYS
    always_comb
    begin
        ways_ext = CW'(ways_reg);
        if (ways_ext == '0)
            eff_ways = CW'(1);
        else if (ways_ext > CW'(MAX_WAYS))
            eff_ways = CW'(MAX_WAYS);
        else
            eff_ways = ways_ext;
        last_idx = PTR_W'(eff_ways - CW'(1));
    end

    // Scan decode
    always_comb
    begin
        cmp_ptr_inc = (cmp_ptr_reg == last_idx) ? '0 : cmp_ptr_reg + PTR_W'(1);
        oldest_inc  = (oldest_reg == last_idx) ? '0 : oldest_reg + PTR_W'(1);
        in_accept   = s_axis_tvalid && s_axis_tready;
        refused     = !cache_ready_reg
                      || ({1'b0, s_axis_tdata[STEP_W-1:0]} >= total_steps_reg);
        hit_now     = valid_reg[cmp_ptr_reg] && (rd_data_reg == step_reg);
        last_now    = (cnt_reg == last_idx);
        empty_now   = !valid_reg[cmp_ptr_reg];
        if (empty_found_reg)
            chosen = empty_ptr_reg;
        else if (empty_now)
            chosen = cmp_ptr_reg;
        else
            chosen = oldest_reg;
        out_free    = !out_valid_reg || m_axis_tready;
        cfg_we      = cfg_valid && cfg_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = refused ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit_now || last_now)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and tag memory control
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_addr       = cmp_ptr_inc;
        tag_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rd_addr       = oldest_reg;
            end
            ST_SCAN:
            begin
                tag_we = !hit_now && last_now && ok_reg;
            end
            ST_FINISH:
            begin
                rd_addr = cmp_ptr_inc;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        step_next        = step_reg;
        ok_next          = ok_reg;
        cmp_ptr_next     = cmp_ptr_reg;
        cnt_next         = cnt_reg;
        empty_found_next = empty_found_reg;
        empty_ptr_next   = empty_ptr_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        valid_next       = valid_reg;
        oldest_next      = oldest_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the request and start the scan at the head
                if (in_accept)
                begin
                    step_next        = s_axis_tdata[STEP_W-1:0];
                    ok_next          = s_axis_tuser;
                    cmp_ptr_next     = oldest_reg;
                    cnt_next         = '0;
                    empty_found_next = 1'b0;
                    res_status_next  = STATUS_REFUSED;
                    res_slot_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit_now)
                begin
                    res_status_next = STATUS_HIT;
                    res_slot_next   = SLOT_W'(cmp_ptr_reg);
                end
                else if (last_now)
                begin
                    // Miss: first empty slot, else evict head; fill if ok_reg
                    if (!empty_found_reg && !empty_now)
                        oldest_next = oldest_inc;
                    valid_next[chosen] = ok_reg;
                    if (ok_reg)
                    begin
                        res_status_next = STATUS_FILLED;
                        res_slot_next   = SLOT_W'(chosen);
                    end
                    else
                    begin
                        res_status_next = STATUS_FETCH_ERR;
                        res_slot_next   = '0;
                    end
                end
                else
                begin
                    // Advance to the next logical position
                    if (empty_now && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_ptr_next   = cmp_ptr_reg;
                    end
                    cmp_ptr_next = cmp_ptr_inc;
                    cnt_next     = cnt_reg + PTR_W'(1);
                end
            end
            ST_FINISH:
            begin
                // Hand the result over once the output register frees
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                end
            end
            default: ;
        endcase

        // A new way count drops every slot and the head
        if (cfg_we && (cfg_index == REG_WAYS_IN_USE))
        begin
            valid_next  = '0;
            oldest_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            oldest_reg      <= '0;
            out_valid_reg   <= 1'b0;
            cache_ready_reg <= 1'b0;
            total_steps_reg <= '0;
            ways_reg        <= DEFAULT_WAYS;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CACHE_READY: cache_ready_reg <= cfg_data[0];
                    REG_TOTAL_STEPS: total_steps_reg <= cfg_data[TOTAL_W-1:0];
                    REG_WAYS_IN_USE: ways_reg        <= cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        ok_reg          <= ok_next;
        cmp_ptr_reg     <= cmp_ptr_next;
        cnt_reg         <= cnt_next;
        empty_found_reg <= empty_found_next;
        empty_ptr_reg   <= empty_ptr_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
    end

    // Tag memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[chosen] <= step_reg;
        rd_data_reg <= tag_mem[rd_addr];
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8 - SLOT_W){1'b0}}, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
